### rtl/cpr_pkg.sv
// shared types and constants for the clock page replacement block
// no dependencies; imported by cpr_engine and clock_page_replacement
package cpr_pkg;

    localparam int PAGE_W   = 20;
    localparam int FCOUNT_W = 5;
    localparam int FIDX_W   = 4;
    localparam int TOTAL_W  = 32;

    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_EVICT
    } cpr_state_t;

    typedef struct packed {
        logic              fault;
        logic              evict_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [FIDX_W-1:0] frame_index;
    } cpr_result_t;

endpackage

### rtl/cpr_engine.sv
// lookup and replacement engine: page memory, valid/reference flags, clock hand
// depends on cpr_pkg
module cpr_engine #(
    parameter int FRAMES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start_acc,
    input  logic [cpr_pkg::PAGE_W-1:0]     page_number,
    input  logic [cpr_pkg::FCOUNT_W-1:0]   frame_count,
    output logic                           busy,
    output logic                           done,
    output cpr_pkg::cpr_result_t           result
);
    import cpr_pkg::*;

    localparam int IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW  = $clog2(FRAMES + 1);
    localparam int NW  = (CW > FCOUNT_W) ? CW : FCOUNT_W;

    cpr_state_t         state_reg, state_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [IW-1:0]      scan_reg, scan_next;
    logic               issue_reg, issue_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IW-1:0]      chk_addr_reg, chk_addr_next;
    logic [IW-1:0]      h_reg, h_next;
    logic [IW-1:0]      hand_reg, hand_next;
    logic [FRAMES-1:0]  valid_reg, valid_next;
    logic [FRAMES-1:0]  ref_reg, ref_next;
    logic [PAGE_W-1:0]  rd_data_reg;

    logic [PAGE_W-1:0]  page_mem [FRAMES];

    logic               mem_re;
    logic               mem_we;
    logic [IW-1:0]      mem_addr;

    logic [NW-1:0]      fc_ext;
    logic [NW-1:0]      n_act;
    logic               last_scan;
    logic               chk_last;
    logic               chk_hit;
    logic               h_last;
    logic               h_ref;
    logic               hand_ok;
    logic [IW-1:0]      slot;
    logic [IW+FIDX_W-1:0] slot_ext;

    // clamp the configured count into 1..FRAMES
    always_comb
    begin
        fc_ext = NW'(frame_count);
        if (fc_ext == '0)
        begin
            n_act = NW'(1);
        end
        else if (fc_ext > NW'(FRAMES))
        begin
            n_act = NW'(FRAMES);
        end
        else
        begin
            n_act = fc_ext;
        end
    end

    assign last_scan = (NW'(scan_reg) + NW'(1)) == n_reg;
    assign chk_last  = (NW'(chk_addr_reg) + NW'(1)) == n_reg;
    assign h_last    = (NW'(h_reg) + NW'(1)) == n_reg;
    assign chk_hit   = chk_valid_reg && valid_reg[chk_addr_reg] && (rd_data_reg == page_reg);
    assign h_ref     = ref_reg[h_reg];
    assign hand_ok   = NW'(hand_reg) < n_reg;
    assign busy      = (state_reg != ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_acc)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (chk_hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (chk_valid_reg && chk_last)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (!h_ref)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        page_next      = page_reg;
        n_next         = n_reg;
        scan_next      = scan_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_addr_next  = chk_addr_reg;
        h_next         = h_reg;
        hand_next      = hand_reg;
        valid_next     = valid_reg;
        ref_next       = ref_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = h_reg;
        done           = 1'b0;
        slot           = h_reg;
        result         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_acc)
                begin
                    page_next  = page_number;
                    n_next     = n_act;
                    scan_next  = '0;
                    issue_next = 1'b1;
                end
            end
            ST_LOOKUP:
            begin
                // reads stream one per cycle, compare trails by the memory latency
                mem_re         = issue_reg;
                mem_addr       = scan_reg;
                chk_valid_next = issue_reg;
                chk_addr_next  = scan_reg;
                if (issue_reg)
                begin
                    issue_next = !last_scan;
                    scan_next  = scan_reg + IW'(1);
                end
                if (chk_hit)
                begin
                    ref_next[chk_addr_reg] = 1'b1;
                    done                   = 1'b1;
                    slot                   = chk_addr_reg;
                    result.fault           = 1'b0;
                end
                else if (chk_valid_reg && chk_last)
                begin
                    h_next = hand_ok ? hand_reg : '0;
                end
            end
            ST_SWEEP:
            begin
                if (h_ref)
                begin
                    ref_next[h_reg] = 1'b0;
                    h_next          = h_last ? '0 : h_reg + IW'(1);
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_addr = h_reg;
                end
            end
            ST_EVICT:
            begin
                mem_we             = 1'b1;
                mem_addr           = h_reg;
                valid_next[h_reg]  = 1'b1;
                ref_next[h_reg]    = 1'b1;
                hand_next          = h_last ? '0 : h_reg + IW'(1);
                done               = 1'b1;
                slot               = h_reg;
                result.fault       = 1'b1;
                result.evict_valid = valid_reg[h_reg];
                result.evicted_page = valid_reg[h_reg] ? rd_data_reg : '0;
            end
            default:
            begin
            end
        endcase
        slot_ext           = (IW + FIDX_W)'(slot);
        result.frame_index = slot_ext[FIDX_W-1:0];
    end

    // page memory; the write and the next request's first read never share a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[mem_addr] <= page_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= page_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            hand_reg      <= '0;
            valid_reg     <= '0;
            ref_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            hand_reg      <= hand_next;
            valid_reg     <= valid_next;
            ref_reg       <= ref_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        n_reg        <= n_next;
        scan_reg     <= scan_next;
        chk_addr_reg <= chk_addr_next;
        h_reg        <= h_next;
    end

`ifndef SYNTH
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_LOOKUP || state_reg == ST_EVICT))
        else $error("result strobe outside lookup or evict");

    a_start_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (start_acc && !busy) |=> (state_reg == ST_LOOKUP))
        else $error("accepted request did not enter lookup");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.fault) |-> !result.evict_valid)
        else $error("hit reported an eviction");

    a_evict_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT) |=>
            (valid_reg[$past(h_reg)] && ref_reg[$past(h_reg)] && state_reg == ST_IDLE))
        else $error("victim frame not filled after evict");
`endif

endmodule

### rtl/clock_page_replacement.sv
// top level of the clock (second chance) page replacement block
// depends on cpr_pkg and cpr_engine
//
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+------------------------
//  request   | page_number                                     | start && !busy
//  result    | fault evict_valid evicted_page frame_index      | done, one cycle, no stall
//            | fault_total                                     |
//  config    | cfg_wdata (frame count)                         | cfg_we
//
// n is the active frame count. a hit ends the lookup at the matching frame; a miss
// reads all n frames, then the hand clears reference bits one at a time until it finds
// a clear one to evict; the page memory has a single read port, one frame per cycle.
// the result strobe comes the cycle busy falls, and a new request may be taken then.
// reset clears all valid and reference bits at once, the hand and the fault count.
// results cannot be held off by the receiver; the done strobe lasts exactly one cycle.
module clock_page_replacement #(
    parameter int FRAMES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [cpr_pkg::PAGE_W-1:0]     page_number,
    input  logic                           cfg_we,
    input  logic [cpr_pkg::FCOUNT_W-1:0]   cfg_wdata,
    output logic                           done,
    output logic                           fault,
    output logic                           evict_valid,
    output logic [cpr_pkg::PAGE_W-1:0]     evicted_page,
    output logic [cpr_pkg::FIDX_W-1:0]     frame_index,
    output logic [cpr_pkg::TOTAL_W-1:0]    fault_total
);
    import cpr_pkg::*;

    logic [FCOUNT_W-1:0] frame_count_reg;
    logic [TOTAL_W-1:0]  count_reg, count_next;
    logic                done_reg;
    cpr_result_t         res_reg;

    logic                start_acc;
    logic                eng_busy;
    logic                eng_done;
    cpr_result_t         eng_res;

    assign start_acc = start && !eng_busy;
    assign busy      = eng_busy;

    cpr_engine #(
        .FRAMES(FRAMES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_acc  (start_acc),
        .page_number(page_number),
        .frame_count(frame_count_reg),
        .busy       (eng_busy),
        .done       (eng_done),
        .result     (eng_res)
    );

    // saturating fault count
    always_comb
    begin
        count_next = count_reg;
        if (eng_done && eng_res.fault && (count_reg != '1))
        begin
            count_next = count_reg + TOTAL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FCOUNT_RESET;
            count_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_count_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            done_reg  <= eng_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            res_reg <= eng_res;
        end
    end

    assign done         = done_reg;
    assign fault        = res_reg.fault;
    assign evict_valid  = res_reg.evict_valid;
    assign evicted_page = res_reg.evicted_page;
    assign frame_index  = res_reg.frame_index;
    assign fault_total  = count_reg;

endmodule
